@@ sv/chs_pkg.sv @@
package chs_pkg;

  // Default sizes of the bucket table and the node pool.
  localparam int DEF_BUCKETS = 256;
  localparam int DEF_POOL    = 1024;

  // Fixed field widths.
  localparam int KEY_W   = 32;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 11;
  localparam int BC_W    = 9;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 16;

  // Reset value of the bucket count register.
  localparam logic [BC_W-1:0] BC_RESET = 9'd256;

  // Register indexes.
  localparam logic REG_BUCKET_COUNT = 1'b0;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

endpackage

@@ sv/chained_hash_set_engine.sv @@
// Chained hash multiset of 32-bit keys.
// Operations arrive on the s_* stream: func 0 adds a key at the head of its
// bucket chain, 1 finds it, 2 deletes the first match, 3 flushes all chains.
// Each word accepted gives exactly one result word on the m_* stream with
// a status and the element count after the operation.
// The bucket is key modulo bucket_count, set over the APB port; the user
// must set it only while the block is idle (not enforced by the block).
// Zero acts as one and values above BUCKETS as BUCKETS. A flush goes
// straight to its result; other operations pass the modulo unit (two
// quotient bits per cycle) and a bucket head read, then add writes its
// node, while find and delete read and compare each chain node in node
// memory, and a delete frees the node. The block takes one word at a time.
// Reset empties every bucket at once through per-bucket valid bits, and
// resets the free list and count; node memories need no clearing pass.
// A new word is taken while a result waits; if the receiver stalls, the
// next result holds in its final state until the output register frees.
module chained_hash_set_engine
  import chs_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int POOL    = DEF_POOL
) (
  input  logic              clk,
  input  logic              rst,
  // APB configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Operation stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // func[1:0], key[33:2], zero pad
  // Result stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // status[1:0], element_count[12:2], zero pad
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(POOL + 1);
  localparam int AW = $clog2(POOL);
  localparam logic [NW-1:0] NIL = NW'(POOL);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_HEAD   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_UNLINK = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]          state;
  logic [BC_W-1:0]     bucket_count;
  logic [FUNC_W-1:0]   op_func;
  logic [KEY_W-1:0]    op_key;
  logic [BW-1:0]       bkt;
  logic [NW-1:0]       cur;
  logic [NW-1:0]       prev;
  logic [NW-1:0]       steps;
  logic [NW-1:0]       free_head;
  logic [NW-1:0]       fresh;
  logic [NW-1:0]       total;
  logic [STAT_W-1:0]   status;
  logic [BUCKETS-1:0]  hvalid;
  logic [STAT_W-1:0]   out_status;
  logic [CNT_W-1:0]    out_count;

  // Memories and their ports.
  logic [NW-1:0]    head_mem [BUCKETS];
  logic [NW-1:0]    link_mem [POOL];
  logic [KEY_W-1:0] key_mem  [POOL];

  logic             head_we, head_re, link_we, link_re, key_we, key_re;
  logic [BW-1:0]    head_wa, head_ra;
  logic [NW-1:0]    head_wd, head_q;
  logic             hv_q;
  logic [AW-1:0]    link_wa, link_ra, key_wa, key_ra;
  logic [NW-1:0]    link_wd, link_q;
  logic [KEY_W-1:0] key_wd, key_q;

  logic [FUNC_W-1:0] in_func;
  logic [KEY_W-1:0]  in_key;
  logic              in_acc;
  logic [BC_W-1:0]   eff_n;
  logic              mod_start, mod_done;
  logic [BC_W-1:0]   mod_rem;
  logic [BW-1:0]     mod_bkt;
  logic [NW-1:0]     head_val;
  logic [NW-1:0]     node_sel;
  logic              walk_go;
  logic              key_hit;

  assign in_func  = s_tdata[FUNC_W-1:0];
  assign in_key   = s_tdata[FUNC_W+KEY_W-1:FUNC_W];
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  assign m_tdata  = {{(OUT_W-STAT_W-CNT_W){1'b0}}, out_count, out_status};

  // APB register access.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? 32'(bucket_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BC_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_BUCKET_COUNT) begin
      bucket_count <= pwdata[BC_W-1:0];
    end
  end

  // Effective modulus: zero acts as one, large values clamp to BUCKETS.
  always_comb begin
    if (bucket_count == '0) begin
      eff_n = BC_W'(1);
    end else if (32'(bucket_count) > 32'(BUCKETS)) begin
      eff_n = BC_W'(BUCKETS);
    end else begin
      eff_n = bucket_count;
    end
  end

  assign mod_start = in_acc && (in_func != FUNC_FLUSH);

  chs_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .key     (in_key),
    .divisor (eff_n),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  assign mod_bkt  = BW'(32'(mod_rem));
  assign head_val = hv_q ? head_q : NIL;
  assign node_sel = (free_head < NIL) ? free_head : ((fresh < NIL) ? fresh : NIL);
  assign walk_go  = (cur < NIL) && (steps < NIL);
  assign key_hit  = (key_q == op_key);

  // Memory port control.
  always_comb begin
    head_we = 1'b0;
    head_wa = bkt;
    head_wd = link_q;
    head_re = 1'b0;
    head_ra = mod_bkt;
    link_we = 1'b0;
    link_wa = cur[AW-1:0];
    link_wd = free_head;
    link_re = 1'b0;
    link_ra = cur[AW-1:0];
    key_we  = 1'b0;
    key_wa  = node_sel[AW-1:0];
    key_wd  = op_key;
    key_re  = 1'b0;
    key_ra  = cur[AW-1:0];
    case (state)
      S_DIV: begin
        if (mod_done) begin
          head_re = 1'b1;
          link_re = (free_head < NIL);
          link_ra = free_head[AW-1:0];
        end
      end
      S_HEAD: begin
        if (op_func == FUNC_ADD && node_sel < NIL) begin
          key_we  = 1'b1;
          link_we = 1'b1;
          link_wa = node_sel[AW-1:0];
          link_wd = head_val;
          head_we = 1'b1;
          head_wd = node_sel;
        end
      end
      S_WALK: begin
        if (walk_go) begin
          key_re  = 1'b1;
          link_re = 1'b1;
        end
      end
      S_CMP: begin
        if (key_hit && op_func == FUNC_DEL) begin
          if (prev < NIL) begin
            link_we = 1'b1;
            link_wa = prev[AW-1:0];
            link_wd = link_q;
          end else begin
            head_we = 1'b1;
          end
        end
      end
      S_UNLINK: begin
        link_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Bucket head memory.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_q <= head_mem[head_ra];
      hv_q   <= hvalid[head_ra];
    end
  end

  // Node link memory.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_q <= link_mem[link_ra];
    end
  end

  // Node key memory.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (key_re) begin
      key_q <= key_mem[key_ra];
    end
  end

  // Operation sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hvalid    <= '0;
      free_head <= NIL;
      fresh     <= '0;
      total     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_func <= in_func;
            op_key  <= in_key;
            if (in_func == FUNC_FLUSH) begin
              hvalid    <= '0;
              free_head <= NIL;
              fresh     <= '0;
              total     <= '0;
              status    <= STAT_OK;
              state     <= S_FIN;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (mod_done) begin
            bkt   <= mod_bkt;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (op_func == FUNC_ADD) begin
            if (node_sel < NIL) begin
              if (free_head < NIL) begin
                free_head <= link_q;
              end else begin
                fresh <= fresh + 1'b1;
              end
              hvalid[bkt] <= 1'b1;
              total       <= total + 1'b1;
              status      <= STAT_OK;
            end else begin
              status <= STAT_FULL;
            end
            state <= S_FIN;
          end else begin
            cur   <= head_val;
            prev  <= NIL;
            steps <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_go) begin
            state <= S_CMP;
          end else begin
            status <= STAT_NOTFOUND;
            state  <= S_FIN;
          end
        end
        S_CMP: begin
          if (key_hit) begin
            status <= STAT_OK;
            state  <= (op_func == FUNC_DEL) ? S_UNLINK : S_FIN;
          end else begin
            prev  <= cur;
            cur   <= link_q;
            steps <= steps + 1'b1;
            state <= S_WALK;
          end
        end
        S_UNLINK: begin
          free_head <= cur;
          if (total != '0) begin
            total <= total - 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= status;
            out_count  <= CNT_W'(32'(total));
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/chs_mod.sv @@
module chs_mod
  import chs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [BC_W-1:0]  divisor,
  output logic             done,
  output logic [BC_W-1:0]  rem
);

  localparam int STEPS = KEY_W / 2;
  localparam int SW    = $clog2(STEPS);

  logic             busy;
  logic [SW-1:0]    cnt;
  logic [KEY_W-1:0] sh;
  logic [BC_W-1:0]  dv;
  logic [BC_W-1:0]  rem_next;

  // Two restoring steps per cycle: shift in a key bit, subtract if it fits.
  always_comb begin
    logic [BC_W:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < 2; i++) begin
      r = {r[BC_W-1:0], sh[KEY_W-1-i]};
      if (r >= {1'b0, dv}) begin
        r = r - {1'b0, dv};
      end
    end
    rem_next = r[BC_W-1:0];
  end

  // Step counter and operand registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= key;
        dv   <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        sh  <= {sh[KEY_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (cnt == SW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
